/* hw/rtl/ritoa_pkg.sv */
// ----------------------------------------------------------------------------
// ritoa_pkg: shared definitions for the radix integer-to-ASCII converter
// Digit bounds, ASCII constants, divider status and the digit-to-character map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ritoa_pkg;

	localparam int MAX_DIGITS = 32;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	localparam int VALUE_W = 32;
	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 8;
	localparam int DIV_CNT_W = $clog2(VALUE_W);

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0]  CH_ALPHA  = 8'h41;
	localparam logic [RADIX_W-1:0] DEC_LIMIT = 6'd10;

	// Handshake between the sequencer and the shared divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
		if (d < DEC_LIMIT) begin
			return CH_ZERO + d_ext;
		end else begin
			return CH_ALPHA + d_ext - {{(CHAR_W-RADIX_W){1'b0}}, DEC_LIMIT};
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ritoa_div.sv */
// ----------------------------------------------------------------------------
// ritoa_div: iterative restoring divider
// Divides a 32-bit value by a 6-bit base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ritoa_div
	import ritoa_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [VALUE_W-1:0]  dividend,
	input  wire logic [RADIX_W-1:0]  divisor,
	output      div_status_t         status,
	output      logic [VALUE_W-1:0]  quotient,
	output      logic [RADIX_W-1:0]  remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [VALUE_W-1:0]   quo_q;
	logic [RADIX_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   dvs_q;

	logic [RADIX_W:0]     partial;
	logic [RADIX_W:0]     dvs_ext;
	logic                 fits;
	logic [RADIX_W:0]     diff;

	// Shift the next dividend bit into the partial remainder and trial-subtract
	assign partial = {rem_q, quo_q[VALUE_W-1]};
	assign dvs_ext = {1'b0, dvs_q};
	assign fits    = (partial >= dvs_ext);
	assign diff    = partial - dvs_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(VALUE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_W-2:0], fits};
			rem_q <= fits ? diff[RADIX_W-1:0] : partial[RADIX_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q;

endmodule

`default_nettype wire

/* hw/rtl/radix_integer_to_ascii_top.sv */
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_top: integer to ASCII string in bases 2 to 36
// Converts a 32-bit unsigned value and emits its digits most significant first.
// ----------------------------------------------------------------------------
// Each input transfer carries a 32-bit unsigned value and a base. The block
// divides by the base repeatedly in one shared restoring divider, which works
// out the 32 quotient bits of each digit in turn, stores the remainders, then
// sends one character per digit, most significant first: '0'-'9' for
// remainders below ten, 'A'-'Z' for ten and above. The final character carries
// last. Each character is read out of the digit store in the read state and
// then presented in the send state, where it holds through any output stall.
// At most 32 digits are stored, enough for a full binary result. A zero value
// gives the single character '0'. A base of 0, 1 or 37..63 gives one result
// with bad_base and last set and digit_char 0, without any division. in_stall
// is high from the accepting edge until the last character of the item has
// been transferred; one item is in work at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_integer_to_ascii_top
	import ritoa_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input channel
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [VALUE_W-1:0]  value,
	input  wire logic [RADIX_W-1:0]  radix,
	// output channel
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [CHAR_W-1:0]   digit_char,
	output      logic                last,
	output      logic                bad_base
);

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,  // wait for an input transfer
		ST_DIV  = 4'b0010,  // divider running on the current quotient
		ST_READ = 4'b0100,  // fetch the next digit from the store
		ST_SEND = 4'b1000   // hold the character until it is transferred
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;     // digits stored, then digits left to send
	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] rd_q;      // registered store read data
	logic               last_q;
	logic               bad_q;

	// Remainder store, least significant digit at entry zero
	logic [RADIX_W-1:0] store_mem [MAX_DIGITS];

	logic               in_xfer;
	logic               out_xfer;
	logic               radix_ok;
	logic               value_zero;

	div_status_t        div_st;
	logic               div_start;
	logic [VALUE_W-1:0] div_dividend;
	logic [RADIX_W-1:0] div_divisor;
	logic [VALUE_W-1:0] div_quo;
	logic [RADIX_W-1:0] div_rem;

	logic               digit_done;   // divider finished a digit
	logic               conv_more;    // another division is needed
	logic [CNT_W-1:0]   cnt_inc;

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = (state_q == ST_SEND);
	assign in_xfer    = in_valid && !in_stall;
	assign out_xfer   = out_valid && !out_stall;

	assign radix_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
	assign value_zero = (value == '0);

	assign digit_done = (state_q == ST_DIV) && div_st.done;
	assign cnt_inc    = cnt_q + 1'b1;
	assign conv_more  = (div_quo != '0) && (cnt_inc != CNT_W'(MAX_DIGITS));

	// Start the divider on a fresh nonzero value, or chain on the last quotient
	assign div_start    = (in_xfer && radix_ok && !value_zero) || (digit_done && conv_more);
	assign div_dividend = (state_q == ST_IDLE) ? value : div_quo;
	assign div_divisor  = (state_q == ST_IDLE) ? radix : radix_q;

	ritoa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.status    (div_st),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (!radix_ok) begin
							// single flagged result, no division
							bad_q   <= 1'b1;
							last_q  <= 1'b1;
							cnt_q   <= '0;
							state_q <= ST_SEND;
						end else if (value_zero) begin
							bad_q   <= 1'b0;
							cnt_q   <= CNT_W'(1);
							state_q <= ST_READ;
						end else begin
							bad_q   <= 1'b0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						cnt_q <= cnt_inc;
						if (!conv_more) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// advance toward the least significant digit
					cnt_q   <= cnt_q - 1'b1;
					last_q  <= (cnt_q == CNT_W'(1));
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_xfer) begin
						state_q <= last_q ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Radix held for chained divisions
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			radix_q <= radix;
		end
	end

	// Store write: a zero value stores one zero digit, otherwise each remainder
	always_ff @(posedge clk) begin
		if (in_xfer && radix_ok && value_zero) begin
			store_mem[0] <= '0;
		end else if (digit_done) begin
			store_mem[cnt_q[IDX_W-1:0]] <= div_rem;
		end
	end

	// Store read, registered; cnt_q is nonzero whenever the read state is entered
	logic [CNT_W-1:0] rd_addr;
	assign rd_addr = cnt_q - 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= store_mem[rd_addr[IDX_W-1:0]];
		end
	end

	// Drop the character to zero on a flagged result
	assign digit_char = bad_q ? '0 : digit_to_ascii(rd_q);
	assign last       = last_q;
	assign bad_base   = bad_q;

endmodule

`default_nettype wire

/* hw/rtl/ritoa_chk.sv */
// ----------------------------------------------------------------------------
// ritoa_chk: port checker for the radix integer-to-ASCII converter
// Watches the top-level ports and flags ordering and payload slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ritoa_chk
	import ritoa_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic [VALUE_W-1:0]  value,
	input wire logic [RADIX_W-1:0]  radix,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [CHAR_W-1:0]   digit_char,
	input wire logic                last,
	input wire logic                bad_base
);

	logic in_xfer;
	logic radix_bad;
	assign in_xfer   = in_valid && !in_stall;
	assign radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_char) && $stable(last)
			&& $stable(bad_base))
		else $error("stalled result changed");

	// A flagged result is single and carries a zero character
	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_base |-> last && (digit_char == '0))
		else $error("bad base result malformed");

	// A bad base is answered next cycle by its flagged result
	a_bad_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && radix_bad |=> out_valid && bad_base)
		else $error("bad base not flagged");

	// No new item while a result is pending
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	// Good characters are digits or capital letters
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_base |->
			((digit_char >= 8'h30) && (digit_char <= 8'h39))
			|| ((digit_char >= 8'h41) && (digit_char <= 8'h5A)))
		else $error("character outside digit set");

endmodule

bind radix_integer_to_ascii_top ritoa_chk u_ritoa_chk (.*);

`default_nettype wire
